>>> rtl/lcnk_pkg.sv
// Package for the loop closure nearest key frame block.
// Shared widths, reset values, register and status codes, controller states
// and the command and status bundles between controller and datapath.
package lcnk_pkg;

    // Default history depth and fixed field widths
    localparam int unsigned MAX_FRAMES_DEF = 1024;
    localparam int unsigned POS_W          = 32;
    localparam int unsigned ABS_W          = 33;
    localparam int unsigned SUM_W          = 34;
    localparam int unsigned DIST_W         = 36;
    localparam int unsigned SKIP_W         = 20;
    localparam int unsigned LIMIT_W        = 19;
    localparam int unsigned STEP_W         = 16;
    localparam int unsigned GAP_W          = 10;
    localparam int unsigned AREA_W         = 32;
    localparam int unsigned IDX_OUT_W      = 10;
    localparam int unsigned STATUS_W       = 3;
    localparam int unsigned CFG_IDX_W      = 2;
    localparam int unsigned CFG_DATA_W     = 32;

    // Best distance before a scan: 1000000 m in Q16.16
    localparam logic [DIST_W-1:0] START_DIST = 36'd65536000000;

    // Register reset values
    localparam logic [STEP_W-1:0] LOOP_STEP_RST   = 16'd5;
    localparam logic [GAP_W-1:0]  MIN_GAP_RST     = 10'd100;
    localparam logic [AREA_W-1:0] DETECT_AREA_RST = 32'd655360;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOOP_STEP   = 2'd0,
        REG_MIN_GAP     = 2'd1,
        REG_DETECT_AREA = 2'd2
    } t_reg_idx;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_SKIPPED  = 3'd0,
        ST_FEW      = 3'd1,
        ST_NO_MATCH = 3'd2,
        ST_MATCH    = 3'd3,
        ST_OVERFLOW = 3'd4
    } t_status;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_SCAN,
        S_DRAIN,
        S_FINISH,
        S_RESULT
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic    take;          // input beat accepted
        logic    early;         // record a result without a search
        t_status early_status;
        logic    scan_start;    // init best distance and scan window
        logic    scan_step;     // read one stored frame
        logic    finish;        // evaluate match, update skip limit
        logic    out_load;      // move result into output register
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic item_ovf;   // last item found the store full
        logic skip;       // skip counter below skip limit
        logic few;        // too few frames stored
        logic no_cand;    // fewer than two frames, nothing to scan
        logic scan_last;  // current read address is the last candidate
        logic pipe_busy;  // distance pipeline still holds reads
        logic out_free;   // output register can take a result
    } t_sts;

endpackage

>>> rtl/loop_closure_nearest_keyframe.sv
// Loop closure nearest key frame search, top level.
// Joins the sequencer (lcnk_ctrl) and the datapath (lcnk_dp); uses lcnk_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one key frame position
//   per beat, x, y and z in signed Q16.16 metres. Each beat yields exactly
//   one result beat on the output channel (o_out_valid / i_out_ready):
//   status, found flag, index of the nearest older frame and its Manhattan
//   distance. Configuration (loop step, min gap, detect area) is written
//   through i_cfg_we, i_cfg_idx and i_cfg_data; the user must write it only
//   while the block is idle, as the block itself does not enforce this.
//   An item that does not search (skipped, too few frames, store full) goes
//   from the decide state straight to the result state. A search reads one
//   stored frame per cycle from the history RAMs, frames 0 to last, with
//   last = frame count - max(min_gap, 2). One item is in work at a time; the
//   next is taken in the cycle after the result loads.
//   Reset (synchronous, active low) empties the frame store and restores the
//   registers; the history RAMs need no clearing pass.
//   When the receiver stalls, the result holds in the output register and a
//   new item is still accepted; its result waits until the register frees.
module loop_closure_nearest_keyframe #(
    parameter int unsigned MAX_FRAMES = lcnk_pkg::MAX_FRAMES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [lcnk_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [lcnk_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [lcnk_pkg::POS_W-1:0]   i_pos_x,
    input  logic signed [lcnk_pkg::POS_W-1:0]   i_pos_y,
    input  logic signed [lcnk_pkg::POS_W-1:0]   i_pos_z,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [lcnk_pkg::STATUS_W-1:0]       o_status,
    output logic                                o_found,
    output logic [lcnk_pkg::IDX_OUT_W-1:0]      o_match_index,
    output logic [lcnk_pkg::DIST_W-1:0]         o_best_distance
);

    lcnk_pkg::t_cmd cmd;
    lcnk_pkg::t_sts sts;

    // Sequencer
    lcnk_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Datapath
    lcnk_dp #(.MAX_FRAMES(MAX_FRAMES)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_pos_z         (i_pos_z),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_status        (o_status),
        .o_found         (o_found),
        .o_match_index   (o_match_index),
        .o_best_distance (o_best_distance)
    );

endmodule

>>> rtl/lcnk_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module lcnk_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/lcnk_ctrl.sv
// Sequencer for the nearest key frame search: accept, decide, scan, drain,
// finish and hand off the result. Depends on lcnk_pkg.
module lcnk_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  lcnk_pkg::t_sts i_sts,
    output lcnk_pkg::t_cmd o_cmd
);

    lcnk_pkg::t_state r_state;
    lcnk_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lcnk_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state            = r_state;
        o_cmd              = '0;
        o_cmd.early_status = lcnk_pkg::ST_SKIPPED;
        o_in_ready         = 1'b0;
        case (r_state)
            lcnk_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = lcnk_pkg::S_DECIDE;
                end
            end
            lcnk_pkg::S_DECIDE: begin
                if (i_sts.item_ovf) begin
                    o_cmd.early        = 1'b1;
                    o_cmd.early_status = lcnk_pkg::ST_OVERFLOW;
                    n_state            = lcnk_pkg::S_RESULT;
                end else if (i_sts.skip) begin
                    o_cmd.early        = 1'b1;
                    o_cmd.early_status = lcnk_pkg::ST_SKIPPED;
                    n_state            = lcnk_pkg::S_RESULT;
                end else if (i_sts.few) begin
                    o_cmd.early        = 1'b1;
                    o_cmd.early_status = lcnk_pkg::ST_FEW;
                    n_state            = lcnk_pkg::S_RESULT;
                end else begin
                    o_cmd.scan_start = 1'b1;
                    n_state = i_sts.no_cand ? lcnk_pkg::S_FINISH : lcnk_pkg::S_SCAN;
                end
            end
            lcnk_pkg::S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = lcnk_pkg::S_DRAIN;
                end
            end
            lcnk_pkg::S_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    n_state = lcnk_pkg::S_FINISH;
                end
            end
            lcnk_pkg::S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = lcnk_pkg::S_RESULT;
            end
            lcnk_pkg::S_RESULT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = lcnk_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lcnk_pkg::S_IDLE;
            end
        endcase
    end

    // Scan reads only follow a decision that started a scan
    a_scan_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lcnk_pkg::S_SCAN && $past(r_state) == lcnk_pkg::S_DECIDE)
            |-> $past(o_cmd.scan_start))
        else $error("scan entered without scan start");

    // Finish never fires while distance reads are still in flight
    a_finish_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> !i_sts.pipe_busy)
        else $error("finish with pipeline busy");

    // Every accepted beat is followed by a decision cycle
    a_take_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.take |=> r_state == lcnk_pkg::S_DECIDE)
        else $error("accepted beat not decided");

endmodule

>>> rtl/lcnk_dp.sv
// Datapath: configuration registers, history RAMs, frame and skip counters,
// the pipelined Manhattan distance scan and the output register.
// Depends on lcnk_pkg and lcnk_ram.
module lcnk_dp #(
    parameter int unsigned MAX_FRAMES = lcnk_pkg::MAX_FRAMES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [lcnk_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [lcnk_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic signed [lcnk_pkg::POS_W-1:0]   i_pos_x,
    input  logic signed [lcnk_pkg::POS_W-1:0]   i_pos_y,
    input  logic signed [lcnk_pkg::POS_W-1:0]   i_pos_z,
    input  lcnk_pkg::t_cmd                      i_cmd,
    output lcnk_pkg::t_sts                      o_sts,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [lcnk_pkg::STATUS_W-1:0]       o_status,
    output logic                                o_found,
    output logic [lcnk_pkg::IDX_OUT_W-1:0]      o_match_index,
    output logic [lcnk_pkg::DIST_W-1:0]         o_best_distance
);

    localparam int unsigned AW    = $clog2(MAX_FRAMES);
    localparam int unsigned FC_W  = $clog2(MAX_FRAMES + 1);
    localparam int unsigned CMP_W = (FC_W > lcnk_pkg::GAP_W + 1) ? FC_W
                                                                   : lcnk_pkg::GAP_W + 1;

    // Configuration registers
    logic [lcnk_pkg::STEP_W-1:0] r_loop_step;
    logic [lcnk_pkg::GAP_W-1:0]  r_min_gap;
    logic [lcnk_pkg::AREA_W-1:0] r_detect_area;

    // Counters and per-item state
    logic [FC_W-1:0]              r_fc;
    logic [lcnk_pkg::SKIP_W-1:0]  r_skip;
    logic [lcnk_pkg::LIMIT_W-1:0] r_limit;
    logic                         r_item_ovf;
    logic signed [lcnk_pkg::POS_W-1:0] r_cur_x;
    logic signed [lcnk_pkg::POS_W-1:0] r_cur_y;
    logic signed [lcnk_pkg::POS_W-1:0] r_cur_z;

    // Scan window and best match
    logic [AW-1:0]               r_scan_addr;
    logic [AW-1:0]               r_last;
    logic [lcnk_pkg::DIST_W-1:0] r_best;
    logic [AW-1:0]               r_best_idx;
    lcnk_pkg::t_status           r_res_status;

    // Distance pipeline
    logic                        r_p1_valid;
    logic [AW-1:0]               r_p1_idx;
    logic                        r_p2_valid;
    logic [AW-1:0]               r_p2_idx;
    logic [lcnk_pkg::ABS_W-1:0]  r_p2_dx;
    logic [lcnk_pkg::ABS_W-1:0]  r_p2_dy;
    logic [lcnk_pkg::ABS_W-1:0]  r_p2_dz;
    logic                        r_p3_valid;
    logic [AW-1:0]               r_p3_idx;
    logic [lcnk_pkg::SUM_W-1:0]  r_p3_sum;

    // Output register
    logic                          r_out_valid;
    logic [lcnk_pkg::STATUS_W-1:0] r_out_status;
    logic                          r_out_found;
    logic [AW-1:0]                 r_out_idx;
    logic [lcnk_pkg::DIST_W-1:0]   r_out_best;

    logic                          full;
    logic                          ram_we;
    logic [lcnk_pkg::POS_W-1:0]    rd_x;
    logic [lcnk_pkg::POS_W-1:0]    rd_y;
    logic [lcnk_pkg::POS_W-1:0]    rd_z;
    logic [CMP_W-1:0]              fc_ext;
    logic [CMP_W-1:0]              gap_ext;
    logic [CMP_W-1:0]              gap_eff;
    logic [CMP_W-1:0]              last_full;
    logic [lcnk_pkg::LIMIT_W-1:0]  half;
    logic [lcnk_pkg::LIMIT_W-1:0]  step_ext;
    logic                          far;

    // Absolute difference of two signed positions, 33 bit magnitude
    function automatic logic [lcnk_pkg::ABS_W-1:0] abs_diff(
        input logic [lcnk_pkg::POS_W-1:0] a,
        input logic [lcnk_pkg::POS_W-1:0] b
    );
        logic signed [lcnk_pkg::ABS_W-1:0] d;
        d = $signed({a[lcnk_pkg::POS_W-1], a}) - $signed({b[lcnk_pkg::POS_W-1], b});
        abs_diff = d[lcnk_pkg::ABS_W-1] ? lcnk_pkg::ABS_W'(-d) : lcnk_pkg::ABS_W'(d);
    endfunction

    assign full   = (r_fc >= FC_W'(MAX_FRAMES));
    assign ram_we = i_cmd.take && !full;

    // History stores, one per axis
    lcnk_ram #(.WIDTH(lcnk_pkg::POS_W), .DEPTH(MAX_FRAMES)) u_ram_x (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_fc[AW-1:0]),
        .i_wdata (i_pos_x),
        .i_re    (i_cmd.scan_step),
        .i_raddr (r_scan_addr),
        .o_rdata (rd_x)
    );

    lcnk_ram #(.WIDTH(lcnk_pkg::POS_W), .DEPTH(MAX_FRAMES)) u_ram_y (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_fc[AW-1:0]),
        .i_wdata (i_pos_y),
        .i_re    (i_cmd.scan_step),
        .i_raddr (r_scan_addr),
        .o_rdata (rd_y)
    );

    lcnk_ram #(.WIDTH(lcnk_pkg::POS_W), .DEPTH(MAX_FRAMES)) u_ram_z (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_fc[AW-1:0]),
        .i_wdata (i_pos_z),
        .i_re    (i_cmd.scan_step),
        .i_raddr (r_scan_addr),
        .o_rdata (rd_z)
    );

    // Decision terms and the last candidate index: n - max(min_gap, 2)
    always_comb begin
        fc_ext    = CMP_W'(r_fc);
        gap_ext   = CMP_W'(r_min_gap);
        gap_eff   = (gap_ext < CMP_W'(2)) ? CMP_W'(2) : gap_ext;
        last_full = fc_ext - gap_eff;
        half      = r_best[lcnk_pkg::DIST_W-1:17];
        step_ext  = lcnk_pkg::LIMIT_W'(r_loop_step);
        far       = r_best > lcnk_pkg::DIST_W'(r_detect_area);
    end

    assign o_sts.item_ovf  = r_item_ovf;
    assign o_sts.skip      = {1'b0, r_limit} > r_skip;
    assign o_sts.few       = fc_ext <= gap_ext;
    assign o_sts.no_cand   = fc_ext < CMP_W'(2);
    assign o_sts.scan_last = (r_scan_addr == r_last);
    assign o_sts.pipe_busy = r_p1_valid || r_p2_valid || r_p3_valid;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loop_step   <= lcnk_pkg::LOOP_STEP_RST;
            r_min_gap     <= lcnk_pkg::MIN_GAP_RST;
            r_detect_area <= lcnk_pkg::DETECT_AREA_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lcnk_pkg::REG_LOOP_STEP: begin
                    r_loop_step <= i_cfg_data[lcnk_pkg::STEP_W-1:0];
                end
                lcnk_pkg::REG_MIN_GAP: begin
                    r_min_gap <= i_cfg_data[lcnk_pkg::GAP_W-1:0];
                end
                lcnk_pkg::REG_DETECT_AREA: begin
                    r_detect_area <= i_cfg_data[lcnk_pkg::AREA_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Frame count, skip counter and skip limit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fc       <= '0;
            r_skip     <= '0;
            r_limit    <= lcnk_pkg::LIMIT_W'(lcnk_pkg::LOOP_STEP_RST);
            r_item_ovf <= 1'b0;
        end else begin
            if (i_cmd.take) begin
                r_item_ovf <= full;
                if (!full) begin
                    r_fc <= r_fc + FC_W'(1);
                    if (r_skip != '1) begin
                        r_skip <= r_skip + lcnk_pkg::SKIP_W'(1);
                    end
                end
            end
            if (i_cmd.finish) begin
                r_skip  <= '0;
                r_limit <= (far && half > step_ext) ? half : step_ext;
            end
        end
    end

    // Hold the newest position for the scan
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_cur_x <= i_pos_x;
            r_cur_y <= i_pos_y;
            r_cur_z <= i_pos_z;
        end
    end

    // Scan address, best match and result status
    always_ff @(posedge i_clk) begin
        if (i_cmd.early) begin
            r_res_status <= i_cmd.early_status;
            r_best       <= '0;
            r_best_idx   <= '0;
        end
        if (i_cmd.scan_start) begin
            r_scan_addr <= '0;
            r_last      <= last_full[AW-1:0];
            r_best      <= lcnk_pkg::START_DIST;
            r_best_idx  <= '0;
        end
        if (i_cmd.scan_step) begin
            r_scan_addr <= r_scan_addr + AW'(1);
        end
        if (r_p3_valid && lcnk_pkg::DIST_W'(r_p3_sum) < r_best) begin
            r_best     <= lcnk_pkg::DIST_W'(r_p3_sum);
            r_best_idx <= r_p3_idx;
        end
        if (i_cmd.finish) begin
            r_res_status <= far ? lcnk_pkg::ST_NO_MATCH : lcnk_pkg::ST_MATCH;
        end
    end

    // Pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
            r_p3_valid <= 1'b0;
        end else begin
            r_p1_valid <= i_cmd.scan_step;
            r_p2_valid <= r_p1_valid;
            r_p3_valid <= r_p2_valid;
        end
    end

    // Distance pipeline: absolute differences, then their sum
    always_ff @(posedge i_clk) begin
        r_p1_idx <= r_scan_addr;
        r_p2_idx <= r_p1_idx;
        r_p2_dx  <= abs_diff(r_cur_x, rd_x);
        r_p2_dy  <= abs_diff(r_cur_y, rd_y);
        r_p2_dz  <= abs_diff(r_cur_z, rd_z);
        r_p3_idx <= r_p2_idx;
        r_p3_sum <= lcnk_pkg::SUM_W'(r_p2_dx) + lcnk_pkg::SUM_W'(r_p2_dy)
                  + lcnk_pkg::SUM_W'(r_p2_dz);
    end

    // Output register: load a result, drop it when the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_found  <= (r_res_status == lcnk_pkg::ST_MATCH);
            r_out_idx    <= r_best_idx;
            r_out_best   <= r_best;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_found         = r_out_found;
    assign o_match_index   = lcnk_pkg::IDX_OUT_W'(r_out_idx);
    assign o_best_distance = r_out_best;

    // Best distance never rises above its start value
    a_best_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p3_valid |-> r_best <= lcnk_pkg::START_DIST)
        else $error("best distance above start value");

    // Frame count stays within the store
    a_fc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fc <= FC_W'(MAX_FRAMES))
        else $error("frame count beyond capacity");

    // A reported match lies within the detect area
    a_match_area: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == lcnk_pkg::ST_MATCH)
            |-> r_out_best <= lcnk_pkg::DIST_W'(r_detect_area))
        else $error("match outside detect area");

    // A finished search restarts the skip counter
    a_skip_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> r_skip == '0)
        else $error("skip counter not cleared after search");

endmodule

>>> verif/tb_loop_closure_nearest_keyframe.sv
`timescale 1ns / 1ps
// Self-checking testbench for the loop closure nearest key frame block.
// Drives key frames and register writes, predicts every result; needs lcnk_pkg.
module tb_loop_closure_nearest_keyframe;

    localparam int unsigned FRAME_DEPTH  = lcnk_pkg::MAX_FRAMES_DEF;
    localparam int unsigned SKIP_SAT     = (1 << lcnk_pkg::SKIP_W) - 1;
    localparam int unsigned CYCLE_LIMIT  = 5_000_000;
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned HOLD_CYCLES  = 3000;
    localparam int unsigned MAX_IDLE     = 17;

    // Register index that maps to no register
    localparam logic [lcnk_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam logic signed [lcnk_pkg::POS_W-1:0] POS_MIN  = 32'sh8000_0000;
    localparam logic signed [lcnk_pkg::POS_W-1:0] POS_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [lcnk_pkg::POS_W-1:0] ONE_M    = 32'sh0001_0000;
    localparam logic signed [lcnk_pkg::POS_W-1:0] NEG_ONE  = -32'sd1;
    localparam logic signed [lcnk_pkg::POS_W-1:0] NEAR_LIM = 32'sh0100_0000;

    typedef struct {
        lcnk_pkg::t_status                status;
        logic                             found;
        logic [lcnk_pkg::IDX_OUT_W-1:0]   match_index;
        logic [lcnk_pkg::DIST_W-1:0]      best_distance;
    } t_frame_result;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_cfg_we;
    logic [lcnk_pkg::CFG_IDX_W-1:0]    i_cfg_idx;
    logic [lcnk_pkg::CFG_DATA_W-1:0]   i_cfg_data;
    logic                              i_in_valid;
    logic                              o_in_ready;
    logic signed [lcnk_pkg::POS_W-1:0] i_pos_x;
    logic signed [lcnk_pkg::POS_W-1:0] i_pos_y;
    logic signed [lcnk_pkg::POS_W-1:0] i_pos_z;
    logic                              o_out_valid;
    logic                              i_out_ready;
    logic [lcnk_pkg::STATUS_W-1:0]     o_status;
    logic                              o_found;
    logic [lcnk_pkg::IDX_OUT_W-1:0]    o_match_index;
    logic [lcnk_pkg::DIST_W-1:0]       o_best_distance;

    // Mirror of the block state and registers
    logic signed [lcnk_pkg::POS_W-1:0] stored_x [FRAME_DEPTH];
    logic signed [lcnk_pkg::POS_W-1:0] stored_y [FRAME_DEPTH];
    logic signed [lcnk_pkg::POS_W-1:0] stored_z [FRAME_DEPTH];
    int          frames_stored   = 0;
    int unsigned skip_count      = 0;
    int unsigned skip_limit      = 32'(lcnk_pkg::LOOP_STEP_RST);
    logic [lcnk_pkg::STEP_W-1:0] cfg_loop_step   = lcnk_pkg::LOOP_STEP_RST;
    logic [lcnk_pkg::GAP_W-1:0]  cfg_min_gap     = lcnk_pkg::MIN_GAP_RST;
    logic [lcnk_pkg::AREA_W-1:0] cfg_detect_area = lcnk_pkg::DETECT_AREA_RST;

    t_frame_result pending_results [$];
    int  mismatch_count = 0;
    bit  tx_idle = 1'b1;
    bit  rx_idle = 1'b1;
    int  rx_hold_cycles = 0;
    int  walk_x = 0;
    int  walk_y = 0;
    int  walk_z = 0;

    loop_closure_nearest_keyframe #(
        .MAX_FRAMES(FRAME_DEPTH)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_pos_z        (i_pos_z),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_found        (o_found),
        .o_match_index  (o_match_index),
        .o_best_distance(o_best_distance)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Absolute difference of one coordinate, exact
    function automatic longint unsigned axis_dist(logic signed [lcnk_pkg::POS_W-1:0] a,
                                                  logic signed [lcnk_pkg::POS_W-1:0] b);
        longint diff;
        diff = longint'(a) - longint'(b);
        return (diff < 0) ? -diff : diff;
    endfunction

    // Store the frame, advance the skip logic and run the nearest frame scan
    function automatic t_frame_result predict_frame(logic signed [lcnk_pkg::POS_W-1:0] px,
                                                    logic signed [lcnk_pkg::POS_W-1:0] py,
                                                    logic signed [lcnk_pkg::POS_W-1:0] pz);
        t_frame_result     r;
        longint unsigned   best;
        longint unsigned   d;
        int                cur;
        int                last;
        int                gap_i;
        int unsigned       half;
        r.status        = lcnk_pkg::ST_SKIPPED;
        r.found         = 1'b0;
        r.match_index   = '0;
        r.best_distance = '0;
        if (frames_stored >= FRAME_DEPTH) begin
            r.status = lcnk_pkg::ST_OVERFLOW;
            return r;
        end
        stored_x[frames_stored] = px;
        stored_y[frames_stored] = py;
        stored_z[frames_stored] = pz;
        frames_stored++;
        if (skip_count < SKIP_SAT) skip_count++;
        if (skip_count < skip_limit) return r;
        gap_i = int'(cfg_min_gap);
        if (frames_stored < gap_i + 1) begin
            r.status = lcnk_pkg::ST_FEW;
            return r;
        end
        // Scan candidates up to frames_stored - max(gap, 2), never the newest frame itself
        cur  = frames_stored - 1;
        best = lcnk_pkg::START_DIST;
        if (frames_stored >= 2) begin
            last = frames_stored - ((gap_i > 2) ? gap_i : 2);
            for (int i = 0; i <= last; i++) begin
                d = axis_dist(stored_x[cur], stored_x[i]) +
                    axis_dist(stored_y[cur], stored_y[i]) +
                    axis_dist(stored_z[cur], stored_z[i]);
                if (d < best) begin
                    best          = d;
                    r.match_index = lcnk_pkg::IDX_OUT_W'(i);
                end
            end
        end
        skip_count      = 0;
        r.best_distance = best[lcnk_pkg::DIST_W-1:0];
        if (best > cfg_detect_area) begin
            half       = 32'(best >> 17);
            skip_limit = (half > cfg_loop_step) ? half : 32'(cfg_loop_step);
            r.status   = lcnk_pkg::ST_NO_MATCH;
        end else begin
            skip_limit = 32'(cfg_loop_step);
            r.status   = lcnk_pkg::ST_MATCH;
            r.found    = 1'b1;
        end
        return r;
    endfunction

    function automatic int spread(int half_width);
        return int'($urandom_range(0, 2 * half_width)) - half_width;
    endfunction

    // Offer one key frame, hold it until accepted, then queue its result
    task automatic send_frame(input logic signed [lcnk_pkg::POS_W-1:0] px,
                              input logic signed [lcnk_pkg::POS_W-1:0] py,
                              input logic signed [lcnk_pkg::POS_W-1:0] pz);
        int            gap;
        t_frame_result want;
        gap = tx_idle ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pos_x    <= px;
        i_pos_y    <= py;
        i_pos_z    <= pz;
        do @(posedge i_clk); while (!o_in_ready);
        want = predict_frame(px, py, pz);
        pending_results.insert(pending_results.size(), want);
    endtask

    // Drop valid and wait until every queued result has come back
    task automatic wait_results_done();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // Write all registers back to back, plus the unmapped index
    task automatic set_config(input logic [lcnk_pkg::STEP_W-1:0] step,
                              input logic [lcnk_pkg::GAP_W-1:0]  gap,
                              input logic [lcnk_pkg::AREA_W-1:0] area);
        logic [lcnk_pkg::CFG_IDX_W-1:0]  idx_list  [4];
        logic [lcnk_pkg::CFG_DATA_W-1:0] data_list [4];
        logic [lcnk_pkg::CFG_DATA_W-1:0] junk;
        junk         = $urandom();
        idx_list[0]  = lcnk_pkg::REG_LOOP_STEP;
        data_list[0] = {junk[31:16], step};
        idx_list[1]  = lcnk_pkg::REG_MIN_GAP;
        data_list[1] = {junk[31:10], gap};
        idx_list[2]  = lcnk_pkg::REG_DETECT_AREA;
        data_list[2] = area;
        idx_list[3]  = REG_UNUSED;
        data_list[3] = ~junk;
        for (int i = 0; i < 4; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx_list[i];
            i_cfg_data <= data_list[i];
            @(posedge i_clk);
        end
        i_cfg_we        <= 1'b0;
        cfg_loop_step   = step;
        cfg_min_gap     = gap;
        cfg_detect_area = area;
    endtask

    // Next frame of a wandering path: mostly small moves, some returns to an
    // old place, and full-range noise only where the frame will not search
    task automatic send_trajectory_frame();
        int                                pick;
        int                                k;
        int unsigned                       next_count;
        bit                                quiet;
        bit                                close_by;
        logic signed [lcnk_pkg::POS_W-1:0] nx;
        logic signed [lcnk_pkg::POS_W-1:0] ny;
        logic signed [lcnk_pkg::POS_W-1:0] nz;
        next_count = (skip_count < SKIP_SAT) ? skip_count + 1 : skip_count;
        quiet = (frames_stored >= FRAME_DEPTH) || (next_count < skip_limit) ||
                (frames_stored + 1 < int'(cfg_min_gap) + 1);
        pick = $urandom_range(0, 99);
        k    = (frames_stored > 0) ? $urandom_range(0, frames_stored - 1) : 0;
        close_by = (frames_stored > 0) &&
                   stored_x[k] > -NEAR_LIM && stored_x[k] < NEAR_LIM &&
                   stored_y[k] > -NEAR_LIM && stored_y[k] < NEAR_LIM &&
                   stored_z[k] > -NEAR_LIM && stored_z[k] < NEAR_LIM;
        if (quiet && pick >= 70) begin
            nx = $urandom();
            ny = $urandom();
            nz = $urandom();
        end else begin
            if (pick < 25 && close_by) begin
                walk_x = stored_x[k] + spread(32'h8000);
                walk_y = stored_y[k] + spread(32'h8000);
                walk_z = stored_z[k] + spread(32'h8000);
            end else begin
                walk_x += spread(32'h20000);
                walk_y += spread(32'h20000);
                walk_z += spread(32'h20000);
            end
            nx = walk_x;
            ny = walk_y;
            nz = walk_z;
        end
        send_frame(nx, ny, nz);
    endtask

    // Reset values: skips until the default step, then too few frames
    task automatic test_reset_values();
        send_frame(POS_MIN, POS_MIN, POS_MIN);
        send_frame(POS_MIN, POS_MIN, POS_MIN);
        send_frame(POS_MAX, POS_MAX, POS_MAX);
        send_frame(NEG_ONE, NEG_ONE, NEG_ONE);
        send_frame('0, '0, '0);
    endtask

    // Zero step and gap: exact match, tie to the lowest index, near miss,
    // then a distance equal to the threshold
    task automatic test_exact_match_and_ties();
        wait_results_done();
        set_config('0, '0, '0);
        send_frame('0, '0, '0);
        send_frame(POS_MIN, POS_MIN, POS_MIN);
        send_frame(32'sd1, '0, '0);
        wait_results_done();
        set_config('0, '0, 32'd1);
        send_frame('0, 32'sd1, '0);
    endtask

    // Step of three holds searches off; widest detect area
    task automatic test_skip_limit_hold();
        wait_results_done();
        set_config(16'd3, 10'd2, 32'hFFFF_FFFF);
        send_frame(ONE_M, '0, '0);
        send_frame(POS_MAX, '0, POS_MIN);
        send_frame(-ONE_M, ONE_M, -ONE_M);
        send_frame(POS_MAX, '0, POS_MIN);
    endtask

    // Widest gap: the old skip limit still applies, then too few frames
    task automatic test_too_few_frames();
        wait_results_done();
        set_config(16'd1, 10'd1023, lcnk_pkg::DETECT_AREA_RST);
        send_frame(ONE_M, -ONE_M, '0);
        send_frame(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555);
        send_frame(32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA);
        send_frame(NEG_ONE, '0, ONE_M);
    endtask

    // Blocks of path frames, each under a fresh random setting
    task automatic test_random_trajectory(input int blocks, input int per_block);
        logic [lcnk_pkg::STEP_W-1:0] step;
        logic [lcnk_pkg::GAP_W-1:0]  gap;
        logic [lcnk_pkg::AREA_W-1:0] area;
        for (int b = 0; b < blocks; b++) begin
            step = lcnk_pkg::STEP_W'(($urandom_range(0, 3) != 0) ? $urandom_range(0, 3)
                                                                 : $urandom_range(0, 8));
            gap  = lcnk_pkg::GAP_W'(($urandom_range(0, 9) < 7) ? $urandom_range(0, 3)
                                                               : $urandom_range(4, 150));
            case ($urandom_range(0, 3))
                0:       area = '0;
                1:       area = lcnk_pkg::DETECT_AREA_RST;
                2:       area = $urandom_range(0, 32'h0040_0000);
                default: area = 32'hFFFF_FFFF;
            endcase
            wait_results_done();
            set_config(step, gap, area);
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            repeat (per_block) send_trajectory_frame();
        end
    endtask

    // Receiver holds off long enough for the input to stall; then the
    // sender pauses until every result is back
    task automatic test_output_backpressure();
        wait_results_done();
        tx_idle        = 1'b0;
        rx_idle        = 1'b0;
        rx_hold_cycles = HOLD_CYCLES;
        repeat (12) send_trajectory_frame();
        wait_results_done();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        repeat (6) send_trajectory_frame();
    endtask

    // Result checker and output ready driver
    initial begin : result_monitor
        t_frame_result want;
        int            stall_left;
        int            hold_left;
        stall_left = 0;
        hold_left  = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: result beat expected none actual status %0d",
                             $time, o_status);
                    mismatch_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, o_status);
                        mismatch_count++;
                    end
                    if (o_found !== want.found) begin
                        $display("%0t: found expected %0d actual %0d",
                                 $time, want.found, o_found);
                        mismatch_count++;
                    end
                    if (o_match_index !== want.match_index) begin
                        $display("%0t: match_index expected %0d actual %0d",
                                 $time, want.match_index, o_match_index);
                        mismatch_count++;
                    end
                    if (o_best_distance !== want.best_distance) begin
                        $display("%0t: best_distance expected %0d actual %0d",
                                 $time, want.best_distance, o_best_distance);
                        mismatch_count++;
                    end
                end
                stall_left = rx_idle ? $urandom_range(0, MAX_IDLE) : 0;
            end
            // Pick up a long hold-off request
            if (rx_hold_cycles > 0) begin
                hold_left      = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            if (hold_left > 0) begin
                i_out_ready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("FAILURE");
        $finish;
    end

    initial begin
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= lcnk_pkg::REG_LOOP_STEP;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        i_pos_x    <= '0;
        i_pos_y    <= '0;
        i_pos_z    <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_exact_match_and_ties();
        test_skip_limit_hold();
        test_too_few_frames();
        test_random_trajectory(5, 54);
        test_output_backpressure();
        test_random_trajectory(5, 54);

        wait_results_done();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
